>>> rtl/tbr_pkg.sv
// ----------------------------------------------------------------------------
// tbr_pkg: shared types and constants for the triangle rasteriser
// Command and job codes, default sizes and the queue status bundle.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int CoordBits  = 10;
    localparam int ColorBits  = 32;
    localparam int QueueDepth = 4;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } command_t;

    typedef enum logic
    {
        JOB_LOAD  = 1'b0,
        JOB_PIXEL = 1'b1
    } job_kind_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> rtl/tbr_fifo.sv
// ----------------------------------------------------------------------------
// tbr_fifo: small synchronous queue
// Register-based circular buffer with a fill count; the head is shown
// combinationally on rdata.
// ----------------------------------------------------------------------------
module tbr_fifo
    import tbr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QueueDepth
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output queue_status_t    status
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem [DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg;
    logic [PtrBits-1:0] wr_ptr_next;
    logic [PtrBits-1:0] rd_ptr_reg;
    logic [PtrBits-1:0] rd_ptr_next;
    logic [CntBits-1:0] count_reg;
    logic [CntBits-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CntBits'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/tbr_front.sv
// ----------------------------------------------------------------------------
// tbr_front: command front end
// Keeps the bounding box, the raster cursor and the active flag; turns each
// load into a load job and each active step into a pixel job.
// ----------------------------------------------------------------------------
module tbr_front
    import tbr_pkg::*;
#(
    parameter int COORD_BITS = CoordBits,
    parameter int JOB_BITS   = 6 * CoordBits + ColorBits + 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_beat,
    input  logic                  command,
    input  logic [COORD_BITS-1:0] vert_a_x,
    input  logic [COORD_BITS-1:0] vert_a_y,
    input  logic [COORD_BITS-1:0] vert_b_x,
    input  logic [COORD_BITS-1:0] vert_b_y,
    input  logic [COORD_BITS-1:0] vert_c_x,
    input  logic [COORD_BITS-1:0] vert_c_y,
    input  logic [ColorBits-1:0]  paint_color,
    output logic                  job_push,
    output logic [JOB_BITS-1:0]   job_data
);

    logic [COORD_BITS-1:0] box_min_x_reg;
    logic [COORD_BITS-1:0] box_min_x_next;
    logic [COORD_BITS-1:0] box_max_x_reg;
    logic [COORD_BITS-1:0] box_max_x_next;
    logic [COORD_BITS-1:0] box_max_y_reg;
    logic [COORD_BITS-1:0] box_max_y_next;
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg;
    logic [COORD_BITS-1:0] cursor_y_next;
    logic                  active_reg;
    logic                  active_next;

    logic [COORD_BITS-1:0] min_x_ab;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] max_x_ab;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] min_y_ab;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_y_ab;
    logic [COORD_BITS-1:0] max_y;
    logic                  is_load;
    logic                  last;

    assign min_x_ab = (vert_a_x < vert_b_x) ? vert_a_x : vert_b_x;
    assign min_x    = (min_x_ab < vert_c_x) ? min_x_ab : vert_c_x;
    assign max_x_ab = (vert_a_x > vert_b_x) ? vert_a_x : vert_b_x;
    assign max_x    = (max_x_ab > vert_c_x) ? max_x_ab : vert_c_x;
    assign min_y_ab = (vert_a_y < vert_b_y) ? vert_a_y : vert_b_y;
    assign min_y    = (min_y_ab < vert_c_y) ? min_y_ab : vert_c_y;
    assign max_y_ab = (vert_a_y > vert_b_y) ? vert_a_y : vert_b_y;
    assign max_y    = (max_y_ab > vert_c_y) ? max_y_ab : vert_c_y;

    assign is_load  = (command == CMD_LOAD);
    assign last     = (cursor_x_reg == box_max_x_reg) && (cursor_y_reg == box_max_y_reg);
    // steps with no triangle are taken and dropped
    assign job_push = in_beat && (is_load || active_reg);

    always_comb
    begin
        if (is_load)
        begin
            job_data = {logic'(JOB_LOAD), 1'b0, paint_color,
                        vert_c_y, vert_c_x, vert_b_y, vert_b_x, vert_a_y, vert_a_x};
        end
        else
        begin
            job_data = {logic'(JOB_PIXEL), last, {ColorBits{1'b0}},
                        {(4 * COORD_BITS){1'b0}}, cursor_y_reg, cursor_x_reg};
        end
    end

    always_comb
    begin
        box_min_x_next = box_min_x_reg;
        box_max_x_next = box_max_x_reg;
        box_max_y_next = box_max_y_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        active_next    = active_reg;
        if (in_beat)
        begin
            if (is_load)
            begin
                box_min_x_next = min_x;
                box_max_x_next = max_x;
                box_max_y_next = max_y;
                cursor_x_next  = min_x;
                cursor_y_next  = min_y;
                active_next    = 1'b1;
            end
            else if (active_reg)
            begin
                if (last)
                begin
                    active_next = 1'b0;
                end
                else if (cursor_x_reg >= box_max_x_reg)
                begin
                    // wrap to the start of the next row
                    cursor_x_next = box_min_x_reg;
                    cursor_y_next = cursor_y_reg + 1'b1;
                end
                else
                begin
                    cursor_x_next = cursor_x_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_x_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            box_min_x_reg <= box_min_x_next;
            box_max_x_reg <= box_max_x_next;
            box_max_y_reg <= box_max_y_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            active_reg    <= active_next;
        end
    end

endmodule

>>> rtl/tbr_back.sv
// ----------------------------------------------------------------------------
// tbr_back: edge-function pipeline
// Three stages: coordinate differences, products, then edge values and the
// sign test. Load jobs update the vertex set and the doubled total area.
// ----------------------------------------------------------------------------
module tbr_back
    import tbr_pkg::*;
#(
    parameter int COORD_BITS = CoordBits,
    parameter int JOB_BITS   = 6 * CoordBits + ColorBits + 2,
    parameter int OUT_BITS   = 2 * CoordBits + ColorBits + 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [JOB_BITS-1:0] job_data,
    input  queue_status_t       job_status,
    output logic                job_pop,
    input  queue_status_t       out_status,
    output logic                out_push,
    output logic [OUT_BITS-1:0] out_data
);

    localparam int DiffBits = COORD_BITS + 1;
    localparam int ProdBits = 2 * COORD_BITS + 2;
    localparam int EdgeBits = 2 * COORD_BITS + 3;
    localparam int ColorLsb = 6 * COORD_BITS;
    localparam int LastBit  = ColorLsb + ColorBits;
    localparam int KindBit  = LastBit + 1;

    // job fields
    logic [COORD_BITS-1:0] job_x [3];
    logic [COORD_BITS-1:0] job_y [3];
    logic [ColorBits-1:0]  job_color;
    logic                  job_last;
    job_kind_t             job_kind;

    // triangle held for pixel jobs
    logic [COORD_BITS-1:0] vx_reg [3];
    logic [COORD_BITS-1:0] vy_reg [3];
    logic [ColorBits-1:0]  color_reg;
    logic signed [EdgeBits-1:0] total_reg;

    logic                  en;
    logic [COORD_BITS-1:0] src_x [3];
    logic [COORD_BITS-1:0] src_y [3];
    logic [COORD_BITS-1:0] p_x;
    logic [COORD_BITS-1:0] p_y;

    // stage 1
    logic                       s1_valid_reg;
    job_kind_t                  s1_kind_reg;
    logic                       s1_last_reg;
    logic [COORD_BITS-1:0]      s1_px_reg;
    logic [COORD_BITS-1:0]      s1_py_reg;
    logic [ColorBits-1:0]       s1_color_reg;
    logic [ColorBits-1:0]       s1_color_next;
    logic signed [DiffBits-1:0] s1_dqx_reg [3];
    logic signed [DiffBits-1:0] s1_dqy_reg [3];
    logic signed [DiffBits-1:0] s1_drx_reg [3];
    logic signed [DiffBits-1:0] s1_dry_reg [3];
    logic signed [DiffBits-1:0] s1_dqx_next [3];
    logic signed [DiffBits-1:0] s1_dqy_next [3];
    logic signed [DiffBits-1:0] s1_drx_next [3];
    logic signed [DiffBits-1:0] s1_dry_next [3];

    // stage 2
    logic                       s2_valid_reg;
    job_kind_t                  s2_kind_reg;
    logic                       s2_last_reg;
    logic [COORD_BITS-1:0]      s2_px_reg;
    logic [COORD_BITS-1:0]      s2_py_reg;
    logic [ColorBits-1:0]       s2_color_reg;
    logic signed [ProdBits-1:0] s2_pa_reg [3];
    logic signed [ProdBits-1:0] s2_pb_reg [3];
    logic signed [ProdBits-1:0] s2_pa_next [3];
    logic signed [ProdBits-1:0] s2_pb_next [3];

    // stage 3
    logic                       s3_valid_reg;
    logic [COORD_BITS-1:0]      s3_px_reg;
    logic [COORD_BITS-1:0]      s3_py_reg;
    logic [ColorBits-1:0]       s3_color_reg;
    logic                       s3_inside_reg;
    logic                       s3_inside_next;
    logic                       s3_last_reg;
    logic signed [EdgeBits-1:0] edge_val [3];
    logic [2:0]                 edge_ok;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job_x[i] = job_data[2 * i * COORD_BITS +: COORD_BITS];
            job_y[i] = job_data[(2 * i + 1) * COORD_BITS +: COORD_BITS];
        end
    end

    assign job_color = job_data[ColorLsb +: ColorBits];
    assign job_last  = job_data[LastBit];
    assign job_kind  = job_kind_t'(job_data[KindBit]);

    // hold the whole pipe while a finished beat cannot leave
    assign en      = !(s3_valid_reg && out_status.full);
    assign job_pop = en && !job_status.empty;

    // a load job runs with p at vertex a, so lane 1 yields the total area
    always_comb
    begin
        if (job_kind == JOB_LOAD)
        begin
            src_x         = job_x;
            src_y         = job_y;
            p_x           = job_x[0];
            p_y           = job_y[0];
            s1_color_next = job_color;
        end
        else
        begin
            src_x         = vx_reg;
            src_y         = vy_reg;
            p_x           = job_x[0];
            p_y           = job_y[0];
            s1_color_next = color_reg;
        end
        for (int i = 0; i < 3; i++)
        begin
            s1_dqx_next[i] = signed'({1'b0, src_x[i]}) - signed'({1'b0, p_x});
            s1_dqy_next[i] = signed'({1'b0, src_y[i]}) - signed'({1'b0, p_y});
            s1_drx_next[i] = signed'({1'b0, src_x[(i + 1) % 3]}) - signed'({1'b0, p_x});
            s1_dry_next[i] = signed'({1'b0, src_y[(i + 1) % 3]}) - signed'({1'b0, p_y});
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_pa_next[i] = s1_dqx_reg[i] * s1_dry_reg[i];
            s2_pb_next[i] = s1_drx_reg[i] * s1_dqy_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            edge_val[i] = {s2_pa_reg[i][ProdBits-1], s2_pa_reg[i]}
                        - {s2_pb_reg[i][ProdBits-1], s2_pb_reg[i]};
            edge_ok[i]  = (edge_val[i] != '0) && (total_reg != '0)
                        && (edge_val[i][EdgeBits-1] == total_reg[EdgeBits-1]);
        end
        s3_inside_next = &edge_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= job_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && (s2_kind_reg == JOB_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop && (job_kind == JOB_LOAD))
        begin
            vx_reg    <= job_x;
            vy_reg    <= job_y;
            color_reg <= job_color;
        end
        if (en && s2_valid_reg && (s2_kind_reg == JOB_LOAD))
        begin
            total_reg <= edge_val[1];
        end
        if (en)
        begin
            s1_kind_reg   <= job_kind;
            s1_last_reg   <= job_last;
            s1_px_reg     <= p_x;
            s1_py_reg     <= p_y;
            s1_color_reg  <= s1_color_next;
            s1_dqx_reg    <= s1_dqx_next;
            s1_dqy_reg    <= s1_dqy_next;
            s1_drx_reg    <= s1_drx_next;
            s1_dry_reg    <= s1_dry_next;

            s2_kind_reg   <= s1_kind_reg;
            s2_last_reg   <= s1_last_reg;
            s2_px_reg     <= s1_px_reg;
            s2_py_reg     <= s1_py_reg;
            s2_color_reg  <= s1_color_reg;
            s2_pa_reg     <= s2_pa_next;
            s2_pb_reg     <= s2_pb_next;

            s3_px_reg     <= s2_px_reg;
            s3_py_reg     <= s2_py_reg;
            s3_color_reg  <= s2_color_reg;
            s3_inside_reg <= s3_inside_next;
            s3_last_reg   <= s2_last_reg;
        end
    end

    assign out_push = s3_valid_reg && !out_status.full;
    assign out_data = {s3_last_reg, s3_inside_reg, s3_color_reg, s3_py_reg, s3_px_reg};

endmodule

>>> rtl/triangle_bbox_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer: bounding-box edge-function triangle rasteriser
// Front end, job queue, edge-function pipeline and result queue.
// ----------------------------------------------------------------------------
// Takes one beat per cycle on the input side while full is low: a load
// stores a triangle and its colour, each step then gives one result per
// position of the bounding box in raster order, with last_in_box set on the
// final one. Pixels on an edge and all pixels of a degenerate triangle are
// reported as outside. Steps with no active triangle are taken and give
// nothing. A step beat is written into the job queue, popped into the first
// pipeline stage (differences), passes the remaining stages (the six
// multipliers, then edge values with sign test) and is pushed into the
// result queue.
// Sustained rate is one item per cycle while the result queue is not full,
// set by the front end's cursor update and the multiplier stage; full rises
// only when the result queue has filled because pop is held low.
module triangle_bbox_rasterizer
    import tbr_pkg::*;
#(
    parameter int COORD_BITS = CoordBits
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  command,
    input  logic [COORD_BITS-1:0] vert_a_x,
    input  logic [COORD_BITS-1:0] vert_a_y,
    input  logic [COORD_BITS-1:0] vert_b_x,
    input  logic [COORD_BITS-1:0] vert_b_y,
    input  logic [COORD_BITS-1:0] vert_c_x,
    input  logic [COORD_BITS-1:0] vert_c_y,
    input  logic [ColorBits-1:0]  paint_color,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [ColorBits-1:0]  pixel_color,
    output logic                  inside_res,
    output logic                  last_in_box
);

    localparam int JobBits = 6 * COORD_BITS + ColorBits + 2;
    localparam int OutBits = 2 * COORD_BITS + ColorBits + 2;

    logic               in_beat;
    logic               job_push;
    logic [JobBits-1:0] job_wdata;
    logic [JobBits-1:0] job_rdata;
    logic               job_pop;
    queue_status_t      job_status;
    logic               res_push;
    logic [OutBits-1:0] res_wdata;
    logic [OutBits-1:0] res_rdata;
    queue_status_t      res_status;

    assign full    = job_status.full;
    assign in_beat = push && !job_status.full;

    tbr_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_BITS   (JobBits)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_beat     (in_beat),
        .command     (command),
        .vert_a_x    (vert_a_x),
        .vert_a_y    (vert_a_y),
        .vert_b_x    (vert_b_x),
        .vert_b_y    (vert_b_y),
        .vert_c_x    (vert_c_x),
        .vert_c_y    (vert_c_y),
        .paint_color (paint_color),
        .job_push    (job_push),
        .job_data    (job_wdata)
    );

    tbr_fifo #(
        .WIDTH (JobBits),
        .DEPTH (QueueDepth)
    ) u_job_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wdata  (job_wdata),
        .pop    (job_pop),
        .rdata  (job_rdata),
        .status (job_status)
    );

    tbr_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_BITS   (JobBits),
        .OUT_BITS   (OutBits)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_data   (job_rdata),
        .job_status (job_status),
        .job_pop    (job_pop),
        .out_status (res_status),
        .out_push   (res_push),
        .out_data   (res_wdata)
    );

    tbr_fifo #(
        .WIDTH (OutBits),
        .DEPTH (QueueDepth)
    ) u_res_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .wdata  (res_wdata),
        .pop    (pop),
        .rdata  (res_rdata),
        .status (res_status)
    );

    assign empty       = res_status.empty;
    assign pixel_x     = res_rdata[COORD_BITS-1:0];
    assign pixel_y     = res_rdata[2*COORD_BITS-1:COORD_BITS];
    assign pixel_color = res_rdata[2*COORD_BITS +: ColorBits];
    assign inside_res  = res_rdata[2*COORD_BITS+ColorBits];
    assign last_in_box = res_rdata[2*COORD_BITS+ColorBits+1];

endmodule
